// File: rtl/core/mrpt_pkg.sv
// Shared types and constants of the Miller-Rabin prime test unit.
// Used by mrpt_ctrl, mrpt_datapath, miller_rabin_prime_test_unit and tb_top; no dependencies.

package mrpt_pkg;

	// width of the arithmetic (candidate bits actually used)
	localparam int NB = 62;
	// width of the number fields on the stream ports
	localparam int DATA_W = 62;
	// division step counter, counts 0..NB
	localparam int CW = $clog2(NB + 1);
	// power-of-two count of n-1, at most NB-1
	localparam int KW = $clog2(NB);
	// packed widths on the stream ports
	localparam int IN_TDATA_W = ((2 * DATA_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((DATA_W + 7) / 8) * 8;

	// controller states, one-hot
	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_CHECK  = 10'b00_0000_0010,
		S_DIV    = 10'b00_0000_0100,
		S_FACTOR = 10'b00_0000_1000,
		S_POW_R  = 10'b00_0001_0000,
		S_POW_B  = 10'b00_0010_0000,
		S_MUL    = 10'b00_0100_0000,
		S_SQ     = 10'b00_1000_0000,
		S_END    = 10'b01_0000_0000,
		S_OUT    = 10'b10_0000_0000
	} state_t;

	// operand selection of the shared modular multiplier
	typedef enum logic [1:0] {
		MUL_RB = 2'd0,  // r = r * b
		MUL_BB = 2'd1,  // b = b * b, exponent shifts right
		MUL_AA = 2'd2   // r = r * r (squaring phase)
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_step;
		logic     fac_step;
		logic     pow_init;
		logic     mul_start;
		logic     mul_step;
		logic     mul_wb;
		mul_sel_t mul_sel;
		logic     sq_dec;
		logic     out_load;
		logic     out_prime;
	} cmd_t;

	typedef struct packed {
		logic n_lt2;
		logic n_is2;
		logic n_even;
		logic div_done;
		logic m_odd;
		logic e_last;
		logic e_lsb;
		logic mul_done;
		logic r_is1;
		logic r_is_nm1;
		logic k_zero;
		logic out_full;
	} sts_t;

endpackage

// File: rtl/core/mrpt_ctrl.sv
// Sequencer of the Miller-Rabin prime test unit: round flow and verdict flag.
// Depends on mrpt_pkg; drives mrpt_datapath through cmd_t, reads sts_t.

module mrpt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	input  mrpt_pkg::sts_t sts,
	output mrpt_pkg::cmd_t cmd
);
	import mrpt_pkg::*;

	state_t   state_q, state_n;
	mul_sel_t sel_q, sel_n;
	logic     fail_q, fail_n;
	logic     comp_q, comp_n;
	logic     last_q;

	assign in_ready = (state_q == S_IDLE);

	// next state and datapath commands
	always_comb begin
		state_n = state_q;
		sel_n   = sel_q;
		fail_n  = fail_q;
		comp_n  = comp_q;
		cmd     = '0;
		cmd.mul_sel = sel_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					fail_n   = 1'b0;
					state_n  = S_CHECK;
				end
			end
			S_CHECK: begin
				// decide small and even candidates without the witness
				if (sts.n_lt2 || (sts.n_even && !sts.n_is2)) begin
					fail_n  = 1'b1;
					state_n = S_END;
				end else if (sts.n_is2) begin
					state_n = S_END;
				end else begin
					state_n = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_n = S_FACTOR;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_FACTOR: begin
				// strip factors of two from n-1
				if (sts.m_odd) begin
					cmd.pow_init = 1'b1;
					state_n      = S_POW_R;
				end else begin
					cmd.fac_step = 1'b1;
				end
			end
			S_POW_R: begin
				if (sts.e_lsb) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MUL_RB;
					sel_n         = MUL_RB;
					state_n       = S_MUL;
				end else begin
					state_n = S_POW_B;
				end
			end
			S_POW_B: begin
				// last exponent bit done: test the power, else square the base
				if (sts.e_last) begin
					state_n = sts.r_is1 ? S_END : S_SQ;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MUL_BB;
					sel_n         = MUL_BB;
					state_n       = S_MUL;
				end
			end
			S_MUL: begin
				if (sts.mul_done) begin
					cmd.mul_wb = 1'b1;
					unique case (sel_q)
						MUL_RB:  state_n = S_POW_B;
						MUL_BB:  state_n = S_POW_R;
						MUL_AA:  state_n = S_SQ;
						default: state_n = S_SQ;
					endcase
				end else begin
					cmd.mul_step = 1'b1;
				end
			end
			S_SQ: begin
				// square up to k times looking for n-1
				if (sts.k_zero) begin
					fail_n  = 1'b1;
					state_n = S_END;
				end else if (sts.r_is_nm1) begin
					state_n = S_END;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MUL_AA;
					cmd.sq_dec    = 1'b1;
					sel_n         = MUL_AA;
					state_n       = S_MUL;
				end
			end
			S_END: begin
				comp_n  = comp_q | fail_q;
				state_n = last_q ? S_OUT : S_IDLE;
			end
			S_OUT: begin
				// hold until the output register is free
				if (!sts.out_full) begin
					cmd.out_load  = 1'b1;
					cmd.out_prime = !comp_q;
					comp_n        = 1'b0;
					state_n       = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= MUL_RB;
			fail_q  <= 1'b0;
			comp_q  <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			sel_q   <= sel_n;
			fail_q  <= fail_n;
			comp_q  <= comp_n;
			if (cmd.load) begin
				last_q <= in_last;
			end
		end
	end

endmodule

// File: rtl/core/mrpt_datapath.sv
// Datapath of the Miller-Rabin prime test unit: witness reduction, bit-serial
// modular multiply, exponent and result registers. Depends on mrpt_pkg.

module mrpt_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mrpt_pkg::cmd_t            cmd,
	output mrpt_pkg::sts_t            sts,
	input  logic [mrpt_pkg::DATA_W-1:0] candidate,
	input  logic [mrpt_pkg::DATA_W-1:0] witness_raw,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      probably_prime,
	output logic [mrpt_pkg::DATA_W-1:0] tested_number
);
	import mrpt_pkg::*;

	logic [NB-1:0] n_q, nm1_q, dv_q;
	logic [NB-1:0] rem_q, quo_q;
	logic [CW-1:0] dcnt_q;
	logic [NB-1:0] e_q;
	logic [KW-1:0] k_q;
	logic [NB-1:0] r_q, b_q;
	logic [NB-1:0] acc_q, add_q, y_q;
	logic          out_valid_q, out_prime_q;
	logic [NB-1:0] out_num_q;

	logic [NB:0]   div_t, div_d;
	logic [NB-1:0] rem_n;
	logic [NB:0]   acc_sum, add_dbl;
	logic [NB-1:0] acc_n, add_n;
	logic [NB-1:0] mx, my;
	logic [NB-1:0] cand_n;

	assign cand_n = candidate[NB-1:0];

	// one restoring division step of raw mod (n-2)
	assign div_t = {rem_q, quo_q[NB-1]};
	assign div_d = div_t - {1'b0, dv_q};
	assign rem_n = div_d[NB] ? div_t[NB-1:0] : div_d[NB-1:0];

	// one shift-add step of the modular multiply
	assign acc_sum = {1'b0, acc_q} + {1'b0, add_q};
	assign add_dbl = {add_q, 1'b0};
	always_comb begin
		acc_n = (acc_sum >= {1'b0, n_q}) ? NB'(acc_sum - {1'b0, n_q}) : acc_sum[NB-1:0];
		add_n = (add_dbl >= {1'b0, n_q}) ? NB'(add_dbl - {1'b0, n_q}) : add_dbl[NB-1:0];
	end

	// multiplier operands
	always_comb begin
		unique case (cmd.mul_sel)
			MUL_RB: begin
				mx = r_q;
				my = b_q;
			end
			MUL_BB: begin
				mx = b_q;
				my = b_q;
			end
			MUL_AA: begin
				mx = r_q;
				my = r_q;
			end
			default: begin
				mx = r_q;
				my = r_q;
			end
		endcase
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= cand_n;
			nm1_q  <= cand_n - NB'(1);
			dv_q   <= cand_n - NB'(2);
			rem_q  <= '0;
			quo_q  <= witness_raw[NB-1:0];
			e_q    <= cand_n - NB'(1);
			k_q    <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[NB-2:0], 1'b0};
		end
		if (cmd.fac_step) begin
			e_q <= {1'b0, e_q[NB-1:1]};
			k_q <= k_q + KW'(1);
		end
		if (cmd.pow_init) begin
			r_q <= NB'(1);
			b_q <= rem_q + NB'(2);
		end
		if (cmd.mul_start) begin
			acc_q <= '0;
			add_q <= mx;
			y_q   <= my;
		end
		if (cmd.mul_step) begin
			if (y_q[0]) begin
				acc_q <= acc_n;
			end
			add_q <= add_n;
			y_q   <= {1'b0, y_q[NB-1:1]};
		end
		if (cmd.mul_wb) begin
			unique case (cmd.mul_sel)
				MUL_RB: r_q <= acc_q;
				MUL_BB: begin
					b_q <= acc_q;
					e_q <= {1'b0, e_q[NB-1:1]};
				end
				MUL_AA: r_q <= acc_q;
				default: r_q <= acc_q;
			endcase
		end
		if (cmd.sq_dec) begin
			k_q <= k_q - KW'(1);
		end
		if (cmd.out_load) begin
			out_prime_q <= cmd.out_prime;
			out_num_q   <= n_q;
		end
	end

	// division step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.load) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + CW'(1);
		end
	end

	// output register: load a verdict, drop it after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign probably_prime = out_prime_q;
	assign tested_number  = DATA_W'(out_num_q);

	// status to the sequencer
	always_comb begin
		sts.n_lt2    = (n_q < NB'(2));
		sts.n_is2    = (n_q == NB'(2));
		sts.n_even   = !n_q[0];
		sts.div_done = (dcnt_q == CW'(NB));
		sts.m_odd    = e_q[0];
		sts.e_last   = (e_q[NB-1:1] == '0);
		sts.e_lsb    = e_q[0];
		sts.mul_done = (y_q == '0);
		sts.r_is1    = (r_q == NB'(1));
		sts.r_is_nm1 = (r_q == nm1_q);
		sts.k_zero   = (k_q == '0);
		sts.out_full = out_valid_q && !out_ready;
	end

endmodule

// File: rtl/core/miller_rabin_prime_test_unit.sv
// Top level of the Miller-Rabin prime test unit: stream ports, sequencer and datapath.
// Depends on mrpt_pkg, mrpt_ctrl and mrpt_datapath.
//
// Usage:
//   Input channel (s_axis_*): one transfer is one test round. tdata carries the
//   candidate in bits 61:0 and the raw witness word in bits 123:62; tlast marks
//   the final round of the candidate. Send the same candidate in every round.
//   Output channel (m_axis_*): one transfer after each final round. tdata holds
//   the candidate judged, tuser is 1 when no round proved it composite.
//   One round at a time, taken only from the idle sequencer. Small and even
//   candidates are decided without the witness. Odd ones go through witness
//   reduction, one division step per candidate bit, the split of n-1 = m * 2^k,
//   then one modular multiply per set bit of m and per squaring of the base,
//   and up to k more; each multiply takes one step per bit of its second
//   operand (up to 62); the bit-serial multiplier is the limiting unit.
//   Reset: clears the sequencer, the composite flag and the output register.
//   Stall: a finished verdict waits in the output register while the next
//   round is taken; a final round that finds the register still full waits
//   for it to drain before its own verdict is loaded.

module miller_rabin_prime_test_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [mrpt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // candidate[61:0], witness_raw[123:62], zero fill
	input  logic                             s_axis_tlast,  // last_round
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [mrpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // tested_number[61:0], zero fill
	output logic                             m_axis_tuser   // probably_prime
);
	import mrpt_pkg::*;

	cmd_t                cmd;
	sts_t                sts;
	logic [DATA_W-1:0]   tested_number;

	mrpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mrpt_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.candidate      (s_axis_tdata[DATA_W-1:0]),
		.witness_raw    (s_axis_tdata[2*DATA_W-1:DATA_W]),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.probably_prime (m_axis_tuser),
		.tested_number  (tested_number)
	);

	// pack the result field into tdata
	assign m_axis_tdata = OUT_TDATA_W'(tested_number);

`ifndef NO_ASSERTIONS
	// a verdict never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("verdict loaded over a pending result");

	// an accepted round starts from the idle sequencer only
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (s_axis_tvalid && s_axis_tready && !cmd.mul_step && !cmd.div_step))
		else $error("round loaded while work is in flight");

	// a multiply result is written back only once the multiplier is exhausted
	a_mul_wb_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_wb |-> (sts.mul_done && !cmd.mul_step && $past(cmd.mul_step || cmd.mul_start)))
		else $error("multiply written back early");
`endif

endmodule

// File: verif/tb_top.sv
// Self-checking testbench of miller_rabin_prime_test_unit: directed and random test rounds
// on the input stream, verdicts predicted in the bench and checked on the output stream.
// Depends on mrpt_pkg and the RTL of miller_rabin_prime_test_unit.

module tb_top;
	import mrpt_pkg::*;

	// cycles without any transfer before the run is declared hung
	localparam int QUIET_LIMIT = 100000;
	// cycles to watch for stray verdicts after the last one arrived
	localparam int DRAIN_CYCLES = 16000;
	localparam logic [63:0] NUMBER_MASK = (64'd1 << NB) - 64'd1;
	localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

	typedef struct {
		logic              prime;
		logic [DATA_W-1:0] number;
	} verdict_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tlast;
	logic                   m_axis_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;

	verdict_t verdict_q[$];
	logic     sticky_composite;
	bit       sender_gaps;
	bit       receiver_gaps;
	int       hold_cycles;
	int       errors;
	int       rounds_sent;
	int       verdicts_seen;
	int       prime_verdicts;

	logic [63:0] prime_pool[12] = '{64'd3, 64'd5, 64'd7, 64'd31, 64'd97, 64'd127, 64'd7919,
		64'd65521, 64'd999983, 64'd1000000007, 64'd2147483647, 64'd4294967291};

	miller_rabin_prime_test_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_tdata),
		.s_axis_tlast (s_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// (x * y) mod n by shift-add, all residues kept below n
	function automatic logic [63:0] mod_product(input logic [63:0] x, input logic [63:0] y,
			input logic [63:0] n);
		logic [63:0] acc;
		logic [63:0] addend;
		logic [63:0] rest;
		acc = '0;
		addend = x % n;
		rest = y;
		while (rest != 64'd0) begin
			if (rest[0]) begin
				acc = acc + addend;
				if (acc >= n)
					acc = acc - n;
			end
			addend = addend << 1;
			if (addend >= n)
				addend = addend - n;
			rest = rest >> 1;
		end
		return acc;
	endfunction

	function automatic logic [63:0] mod_power(input logic [63:0] base, input logic [63:0] expo,
			input logic [63:0] n);
		logic [63:0] acc;
		logic [63:0] sq;
		logic [63:0] rest;
		acc = 64'd1 % n;
		sq = base % n;
		rest = expo;
		while (rest != 64'd0) begin
			if (rest[0])
				acc = mod_product(acc, sq, n);
			sq = mod_product(sq, sq, n);
			rest = rest >> 1;
		end
		return acc;
	endfunction

	// 1 when this round proves n composite
	function automatic logic round_disproves(input logic [63:0] n, input logic [63:0] raw);
		logic [63:0] odd_part;
		logic [63:0] a;
		int          twos;
		int          i;
		if (n < 64'd2)
			return 1'b1;
		if (n == 64'd2)
			return 1'b0;
		if (!n[0])
			return 1'b1;
		odd_part = n - 64'd1;
		twos = 0;
		while (!odd_part[0]) begin
			odd_part = odd_part >> 1;
			twos++;
		end
		a = mod_power(raw % (n - 64'd2) + 64'd2, odd_part, n);
		if (a == 64'd1)
			return 1'b0;
		i = 0;
		while (i < twos && a != n - 64'd1) begin
			a = mod_product(a, a, n);
			i++;
		end
		return i >= twos;
	endfunction

	function automatic logic [DATA_W-1:0] rand_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[DATA_W-1:0];
	endfunction

	// candidate mix: mostly cheap ones, a few at full width
	function automatic logic [DATA_W-1:0] pick_candidate();
		logic [63:0] v;
		int          bits;
		case ($urandom_range(0, 19))
			0: v = {2'b00, rand_word()};
			1, 2: v = 64'($urandom_range(0, 4));
			3: v = {2'b00, rand_word()} & ~64'd1;
			4, 5, 6, 7, 8, 9, 10: v = prime_pool[$urandom_range(0, 11)];
			11, 12, 13, 14, 15: v = 64'($urandom_range(3, 65535) | 1);
			default: begin
				bits = $urandom_range(17, 40);
				v = ({2'b00, rand_word()} & ((64'd1 << bits) - 64'd1)) | 64'd1;
			end
		endcase
		return v[DATA_W-1:0];
	endfunction

	// offer one round, wait for its transfer, then predict its effect
	task automatic offer_round(input logic [DATA_W-1:0] cand, input logic [DATA_W-1:0] raw,
			input logic last);
		int          gap;
		logic [63:0] n;
		verdict_t    v;
		gap = sender_gaps ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_TDATA_W - 2 * DATA_W){1'b0}}, raw, cand};
		s_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		rounds_sent++;
		n = {2'b00, cand} & NUMBER_MASK;
		if (round_disproves(n, {2'b00, raw} & NUMBER_MASK))
			sticky_composite = 1'b1;
		if (last) begin
			v.prime = !sticky_composite;
			v.number = n[DATA_W-1:0];
			verdict_q.push_back(v);
			sticky_composite = 1'b0;
		end
	endtask

	// zero, one, two, even numbers and three, whose base is always two
	task automatic test_trivial_candidates();
		offer_round('0, '0, 1'b1);
		offer_round(62'd1, ALL_ONES, 1'b1);
		offer_round(62'd2, ALL_ONES, 1'b1);
		offer_round(62'd4, '0, 1'b1);
		offer_round(ALL_ONES - 62'd1, rand_word(), 1'b1);
		offer_round(62'd3, '0, 1'b0);
		offer_round(62'd3, ALL_ONES, 1'b0);
		offer_round(62'd3, rand_word(), 1'b1);
	endtask

	// primes from tiny to the largest below the field width
	task automatic test_known_primes();
		offer_round(62'd5, ALL_ONES, 1'b1);
		offer_round(62'd97, '0, 1'b0);
		offer_round(62'd97, rand_word(), 1'b1);
		offer_round(62'd65521, rand_word(), 1'b1);
		offer_round(62'h1FFF_FFFF_FFFF_FFFF, rand_word(), 1'b0);
		offer_round(62'h1FFF_FFFF_FFFF_FFFF, ALL_ONES, 1'b1);
		offer_round(62'h3FFF_FFFF_FFFF_FFC7, rand_word(), 1'b1);
	endtask

	// odd composites, including a Carmichael number and a strong pseudoprime
	task automatic test_composites();
		offer_round(62'd9, rand_word(), 1'b1);
		offer_round(62'd561, '0, 1'b0);
		offer_round(62'd561, rand_word(), 1'b1);
		offer_round(ALL_ONES, rand_word(), 1'b1);
		// bases two and three let it pass, base eleven catches it
		offer_round(62'd3215031751, 62'd0, 1'b0);
		offer_round(62'd3215031751, 62'd1, 1'b0);
		offer_round(62'd3215031751, 62'd9, 1'b1);
	endtask

	// candidate swapped within a test: the flag is shared, the echo follows the last round
	task automatic test_changed_candidate();
		offer_round(62'd15, rand_word(), 1'b0);
		offer_round(62'd13, rand_word(), 1'b1);
		offer_round(62'd97, rand_word(), 1'b0);
		offer_round(62'd2, rand_word(), 1'b1);
	endtask

	// well-formed tests with random content, plus stray and unterminated rounds
	task automatic test_random_rounds(input int budget);
		int                sent;
		int                rounds;
		int                r;
		logic [DATA_W-1:0] cand;
		sent = 0;
		while (sent < budget) begin
			sender_gaps = ($urandom_range(0, 3) != 0);
			receiver_gaps = ($urandom_range(0, 3) != 0);
			cand = pick_candidate();
			rounds = $urandom_range(1, 4);
			for (r = 0; r < rounds; r++) begin
				if (r != 0 && $urandom_range(0, 9) == 0) begin
					offer_round(pick_candidate(), rand_word(), 1'b0);
					sent++;
				end
				offer_round(cand, rand_word(),
					r == rounds - 1 && $urandom_range(0, 9) != 0);
				sent++;
			end
		end
	endtask

	// stall the output for a long stretch while fast tests keep coming
	task automatic test_output_backpressure();
		int i;
		sender_gaps = 1'b0;
		receiver_gaps = 1'b0;
		hold_cycles = 400;
		for (i = 0; i < 8; i++)
			offer_round((i % 3 == 0) ? 62'd7 : 62'($urandom_range(0, 20) * 2), rand_word(), 1'b1);
		receiver_gaps = 1'b1;
		sender_gaps = 1'b1;
	endtask

	// check each verdict against the oldest prediction
	initial begin : verdict_sink
		int       stall;
		verdict_t want;
		stall = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_tready) begin
				verdicts_seen++;
				if (m_axis_tuser)
					prime_verdicts++;
				if (verdict_q.size() == 0) begin
					$error("unexpected verdict for %0d, probably_prime %0b",
						m_axis_tdata[DATA_W-1:0], m_axis_tuser);
					errors++;
				end else begin
					want = verdict_q.pop_front();
					if (m_axis_tuser !== want.prime) begin
						$error("probably_prime: expected %0b, got %0b", want.prime,
							m_axis_tuser);
						errors++;
					end
					if (m_axis_tdata[DATA_W-1:0] !== want.number) begin
						$error("tested_number: expected %0d, got %0d", want.number,
							m_axis_tdata[DATA_W-1:0]);
						errors++;
					end
				end
				stall = receiver_gaps ? $urandom_range(0, 4) : 0;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// end the run when no transfer happens for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : run
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		arst_n <= 1'b0;
		sticky_composite = 1'b0;
		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
		hold_cycles = 0;
		errors = 0;
		rounds_sent = 0;
		verdicts_seen = 0;
		prime_verdicts = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_trivial_candidates();
		test_known_primes();
		test_composites();
		test_changed_candidate();
		test_random_rounds(66);
		test_output_backpressure();

		// drain, then watch for anything left over
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d test rounds and checked %0d verdicts (%0d prime, %0d composite),",
			rounds_sent, verdicts_seen, prime_verdicts, verdicts_seen - prime_verdicts);
		$display("covering trivial, prime, pseudoprime, mixed-candidate and stalled-output cases.");
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/mrpt_pkg.sv
rtl/core/mrpt_ctrl.sv
rtl/core/mrpt_datapath.sv
rtl/core/miller_rabin_prime_test_unit.sv
verif/tb_top.sv
